@@ rtl/gos_pkg.sv @@
// ----------------------------------------------------------------------------
// gos_pkg
// Shared types, codes and constants of the grid obstacle smoothing block.
// ----------------------------------------------------------------------------
package gos_pkg;

	// Default storage geometry and run length
	localparam int unsigned GOS_MAX_SIDE   = 128;
	localparam int unsigned GOS_PASS_COUNT = 3;

	// Reset value of the grid side register
	localparam logic [7:0] GOS_GRID_RESET = 8'd128;

	// A tile turns when more than this many neighbors agree
	localparam logic [3:0] GOS_MAJORITY = 4'd4;

	// Request kinds
	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_RUN   = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Tile states
	typedef enum logic [1:0] {
		TILE_POSSIBLE = 2'd0,
		TILE_FREE     = 2'd1,
		TILE_BLOCKED  = 2'd2,
		TILE_USED     = 2'd3
	} tile_t;

	// Neighbor offset codes along one axis
	typedef enum logic [1:0] {
		OFS_NEG  = 2'd0,
		OFS_ZERO = 2'd1,
		OFS_POS  = 2'd2
	} ofs_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESP,
		ST_CENTER_RD,
		ST_CENTER_CHK,
		ST_NB,
		ST_NB_DRAIN,
		ST_DECIDE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       accept;     // input beat taken this cycle
		logic       rd_center;  // read the tile at the scan position
		logic       nb_read;    // read one neighbor
		logic [2:0] nb_idx;     // which neighbor
		logic       nb_clear;   // clear the neighbor counts
		logic       decide;     // apply the majority rule to the scan tile
		logic       advance;    // step the scan position
		logic       load_out;   // load the result register
	} gos_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic side_zero;        // effective grid side is zero
		logic center_possible;  // scan tile read back as possible
		logic last_tile;        // scan is at the last tile of the last pass
		logic out_free;         // result register can take a new result
	} gos_sts_t;

	// Column offset of neighbor idx
	function automatic ofs_t nb_dx(input logic [2:0] idx);
		ofs_t r;
		case (idx)
			3'd0, 3'd1, 3'd2: r = OFS_NEG;
			3'd3, 3'd4:       r = OFS_ZERO;
			default:          r = OFS_POS;
		endcase
		return r;
	endfunction

	// Row offset of neighbor idx
	function automatic ofs_t nb_dy(input logic [2:0] idx);
		ofs_t r;
		case (idx)
			3'd0, 3'd3, 3'd5: r = OFS_NEG;
			3'd1, 3'd6:       r = OFS_ZERO;
			default:          r = OFS_POS;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/gos_ctrl.sv @@
// ----------------------------------------------------------------------------
// gos_ctrl
// Request sequencer: takes input beats, walks the smoothing scan tile by
// tile and hands results to the output register.
// ----------------------------------------------------------------------------
module gos_ctrl
	import gos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_req,
	output logic       in_ready,
	input  gos_sts_t   sts,
	output gos_cmd_t   cmd
);

	state_t     state_q, state_d;
	logic [2:0] nb_idx_q;

	// State register and neighbor counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nb_idx_q <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NB) begin
				nb_idx_q <= nb_idx_q + 3'd1;
			end else begin
				nb_idx_q <= 3'd0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_req)
						REQ_WRITE, REQ_READ: state_d = ST_RESP;
						REQ_RUN:             state_d = sts.side_zero ? ST_RESP : ST_CENTER_RD;
						default:             state_d = ST_IDLE;
					endcase
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CENTER_RD:  state_d = ST_CENTER_CHK;
			ST_CENTER_CHK: begin
				if (sts.center_possible) begin
					state_d = ST_NB;
				end else begin
					state_d = sts.last_tile ? ST_RESP : ST_CENTER_RD;
				end
			end
			ST_NB: begin
				if (nb_idx_q == 3'd7) begin
					state_d = ST_NB_DRAIN;
				end
			end
			ST_NB_DRAIN: state_d = ST_DECIDE;
			ST_DECIDE:   state_d = sts.last_tile ? ST_RESP : ST_CENTER_RD;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		cmd.nb_idx = nb_idx_q;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RESP: begin
				cmd.load_out = sts.out_free;
			end
			ST_CENTER_RD: begin
				cmd.rd_center = 1'b1;
			end
			ST_CENTER_CHK: begin
				cmd.nb_clear = sts.center_possible;
				cmd.advance  = !sts.center_possible;
			end
			ST_NB: begin
				cmd.nb_read = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide  = 1'b1;
				cmd.advance = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/gos_dp.sv @@
// ----------------------------------------------------------------------------
// gos_dp
// Tile memory, scan position, neighbor counts, run totals and the result
// register of the grid obstacle smoothing block.
// ----------------------------------------------------------------------------
module gos_dp
	import gos_pkg::*;
#(
	parameter int unsigned MAX_SIDE   = GOS_MAX_SIDE,
	parameter int unsigned PASS_COUNT = GOS_PASS_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic [1:0]  in_req,
	input  logic [6:0]  in_pos_x,
	input  logic [6:0]  in_pos_y,
	input  logic [1:0]  in_tile,
	input  gos_cmd_t    cmd,
	output gos_sts_t    sts,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_status,
	output logic [1:0]  out_tile,
	output logic [15:0] out_blocked,
	output logic [15:0] out_free
);

	localparam int unsigned CW    = $clog2(MAX_SIDE);
	localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
	localparam int unsigned AW    = 2 * CW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned PW    = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;

	logic [7:0]    grid_q;
	logic [8:0]    side9;
	logic [SW-1:0] side;
	logic [SW-1:0] side_m1;

	logic [1:0]    mem [0:DEPTH-1];
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [1:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [1:0]    rd_data_q;

	logic [CW-1:0] x_q, y_q;
	logic [PW-1:0] pass_q;
	logic          x_first, y_first, x_last, y_last, pass_last;

	logic [CW-1:0] in_x, in_y;
	logic          in_err;
	logic          err_q;
	logic [1:0]    req_q;

	ofs_t          dx, dy;
	logic [CW-1:0] nb_x, nb_y;
	logic          nb_inrange;
	logic          nb_pend_q;
	logic [3:0]    cnt_blk_q, cnt_free_q;
	logic          turn_blk, turn_free;
	logic [15:0]   tot_blk_q, tot_free_q;

	logic          out_valid_q;
	logic          out_status_q;
	logic [1:0]    out_tile_q;
	logic [15:0]   out_blk_q, out_free_q;

	// Grid side register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= GOS_GRID_RESET;
		end else if (cfg_we) begin
			grid_q <= cfg_wdata;
		end
	end

	// Clamp the side to the storage size
	assign side9   = ({1'b0, grid_q} > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : {1'b0, grid_q};
	assign side    = SW'(side9);
	assign side_m1 = side - SW'(1);

	// Decode the request position
	assign in_x   = CW'({2'b00, in_pos_x});
	assign in_y   = CW'({2'b00, in_pos_y});
	assign in_err = ({2'b00, in_pos_x} >= side9) || ({2'b00, in_pos_y} >= side9);

	// Scan edges
	assign x_first   = (x_q == '0);
	assign y_first   = (y_q == '0);
	assign x_last    = (SW'(x_q) == side_m1);
	assign y_last    = (SW'(y_q) == side_m1);
	assign pass_last = (pass_q == PW'(PASS_COUNT - 1));

	// Neighbor position and its in-grid check
	assign dx = nb_dx(cmd.nb_idx);
	assign dy = nb_dy(cmd.nb_idx);
	always_comb begin
		nb_x       = x_q;
		nb_y       = y_q;
		nb_inrange = 1'b1;
		case (dx)
			OFS_NEG: begin
				nb_x       = x_q - CW'(1);
				nb_inrange = nb_inrange && !x_first;
			end
			OFS_POS: begin
				nb_x       = x_q + CW'(1);
				nb_inrange = nb_inrange && !x_last;
			end
			default: nb_x = x_q;
		endcase
		case (dy)
			OFS_NEG: begin
				nb_y       = y_q - CW'(1);
				nb_inrange = nb_inrange && !y_first;
			end
			OFS_POS: begin
				nb_y       = y_q + CW'(1);
				nb_inrange = nb_inrange && !y_last;
			end
			default: nb_y = y_q;
		endcase
	end

	// Majority decision on the completed counts
	assign turn_blk  = (cnt_blk_q > GOS_MAJORITY);
	assign turn_free = !turn_blk && (cnt_free_q > GOS_MAJORITY);

	// Memory port selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {in_x, in_y};
		wr_data = in_tile;
		if (cmd.decide) begin
			wr_en   = turn_blk || turn_free;
			wr_addr = {x_q, y_q};
			wr_data = turn_blk ? TILE_BLOCKED : TILE_FREE;
		end else if (cmd.accept && (in_req == REQ_WRITE) && !in_err) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {in_x, in_y};
		if (cmd.nb_read) begin
			rd_en   = 1'b1;
			rd_addr = {nb_x, nb_y};
		end else if (cmd.rd_center) begin
			rd_en   = 1'b1;
			rd_addr = {x_q, y_q};
		end else if (cmd.accept && (in_req == REQ_READ)) begin
			rd_en = 1'b1;
		end
	end

	// Tile memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Latch the request kind and position error
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_req;
			err_q <= in_err;
		end
	end

	// Scan position: y inner, x outer, then pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			pass_q <= '0;
		end else if (cmd.accept) begin
			x_q    <= '0;
			y_q    <= '0;
			pass_q <= '0;
		end else if (cmd.advance) begin
			if (y_last) begin
				y_q <= '0;
				if (x_last) begin
					x_q    <= '0;
					pass_q <= pass_q + PW'(1);
				end else begin
					x_q <= x_q + CW'(1);
				end
			end else begin
				y_q <= y_q + CW'(1);
			end
		end
	end

	// Count neighbors in the cycle after their reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_pend_q  <= 1'b0;
			cnt_blk_q  <= 4'd0;
			cnt_free_q <= 4'd0;
		end else begin
			nb_pend_q <= cmd.nb_read && nb_inrange;
			if (cmd.nb_clear) begin
				cnt_blk_q  <= 4'd0;
				cnt_free_q <= 4'd0;
			end else if (nb_pend_q) begin
				if (rd_data_q == TILE_BLOCKED) begin
					cnt_blk_q <= cnt_blk_q + 4'd1;
				end
				if (rd_data_q == TILE_FREE) begin
					cnt_free_q <= cnt_free_q + 4'd1;
				end
			end
		end
	end

	// Run totals, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_blk_q  <= 16'd0;
			tot_free_q <= 16'd0;
		end else if (cmd.accept) begin
			tot_blk_q  <= 16'd0;
			tot_free_q <= 16'd0;
		end else if (cmd.decide) begin
			if (turn_blk && (tot_blk_q != 16'hFFFF)) begin
				tot_blk_q <= tot_blk_q + 16'd1;
			end
			if (turn_free && (tot_free_q != 16'hFFFF)) begin
				tot_free_q <= tot_free_q + 16'd1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (req_q == REQ_RUN) begin
				out_status_q <= 1'b0;
				out_tile_q   <= TILE_POSSIBLE;
				out_blk_q    <= tot_blk_q;
				out_free_q   <= tot_free_q;
			end else begin
				out_status_q <= err_q;
				out_tile_q   <= ((req_q == REQ_READ) && !err_q) ? rd_data_q : TILE_POSSIBLE;
				out_blk_q    <= 16'd0;
				out_free_q   <= 16'd0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_tile    = out_tile_q;
	assign out_blocked = out_blk_q;
	assign out_free    = out_free_q;

	// Status to the controller
	assign sts.side_zero       = (side == '0);
	assign sts.center_possible = (rd_data_q == TILE_POSSIBLE);
	assign sts.last_tile       = x_last && y_last && pass_last;
	assign sts.out_free        = !out_valid_q || out_ready;

endmodule

@@ rtl/grid_obstacle_smoothing.sv @@
// ----------------------------------------------------------------------------
// grid_obstacle_smoothing
// Square grid of 2-bit tiles with write, read and majority smoothing runs.
//
// Channel   Dir  Handshake                     Content
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: pos_x, pos_y, tile_in
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: tile_out, totals
// cfg       in   cfg_we                        cfg_wdata: grid_size
//
// Write and read: the beat is taken in the idle state, the result register is
// loaded from the response state, and the next beat is taken back in idle.
// Run: each tile takes a center read and check; a possible one adds eight
// neighbor reads through the single memory read port, a drain and a decide,
// over side*side tiles and PASS_COUNT passes.
// One request is in work at a time; a stalled result holds the block only
// when the next result is ready to load. Reset needs no memory clearing pass.
// ----------------------------------------------------------------------------
module grid_obstacle_smoothing
	import gos_pkg::*;
#(
	parameter int unsigned MAX_SIDE   = GOS_MAX_SIDE,
	parameter int unsigned PASS_COUNT = GOS_PASS_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,       // grid_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // pos_x[6:0], pos_y[13:7], tile_in[15:14]
	input  logic [1:0]  s_axis_tuser,    // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,    // tile_out[1:0], set_blocked_total[17:2],
	                                     // set_free_total[33:18], zero[39:34]
	output logic [0:0]  m_axis_tuser     // status[0]
);

	gos_cmd_t    cmd;
	gos_sts_t    sts;
	logic        out_status;
	logic [1:0]  out_tile;
	logic [15:0] out_blocked;
	logic [15:0] out_free;

	// Sequencer
	gos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_req   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Memory, counters and result register
	gos_dp #(
		.MAX_SIDE   (MAX_SIDE),
		.PASS_COUNT (PASS_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_req      (s_axis_tuser),
		.in_pos_x    (s_axis_tdata[6:0]),
		.in_pos_y    (s_axis_tdata[13:7]),
		.in_tile     (s_axis_tdata[15:14]),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (out_status),
		.out_tile    (out_tile),
		.out_blocked (out_blocked),
		.out_free    (out_free)
	);

	// Pack the result beat
	assign m_axis_tdata = {6'd0, out_free, out_blocked, out_tile};
	assign m_axis_tuser = out_status;

endmodule
